// ----- src/sdfc_pkg.sv -----
// shared types and constants of the strobed digit frame capture block
`timescale 1ns / 1ps

package sdfc_pkg;

	// register widths and reset values
	localparam int TIMEOUT_W = 16;
	localparam int SIGNS_W   = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
	localparam logic [SIGNS_W-1:0]   SIGNS_RESET   = 8'd32;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNS_COUNT = 1'b1;

	// capture counter width, saturates at its all-ones value
	localparam int COUNT_W = 8;

	// control fields of one sample
	typedef struct packed {
		logic       restart;
		logic       ms_tick;
		logic       buffer_free;
		logic [3:0] strobe;       // strobe[0] is B1, strobe[3] is B4
		logic       frame_line;
	} smp_flags_t;

	// flag fields of one result
	typedef struct packed {
		logic timeout_error;
		logic frame_done;
		logic frame_start;
		logic capture_valid;
	} res_flags_t;

endpackage

// ----- src/sdfc_in_stage.sv -----
// input register stage: takes one sample request per cycle into the s1 register while in_ready is high
`timescale 1ns / 1ps

module sdfc_in_stage
	import sdfc_pkg::*;
#(
	parameter int CODE_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  smp_flags_t            in_flags,
	input  logic [CODE_WIDTH-1:0] in_code,
	input  logic                  advance,
	output logic                  valid_s1,
	output smp_flags_t            flags_s1,
	output logic [CODE_WIDTH-1:0] code_s1
);

	logic take;

	// stage is free when empty or when its content moves on this cycle
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	// stage valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			flags_s1 <= in_flags;
			code_s1  <= in_code;
		end
	end

endmodule

// ----- src/sdfc_step.sv -----
// frame capture sequencer: state, timer, counter and the result register
`timescale 1ns / 1ps

module sdfc_step
	import sdfc_pkg::*;
#(
	parameter int CODE_WIDTH  = 8,
	parameter int TIMER_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  smp_flags_t            flags_s1,
	input  logic [CODE_WIDTH-1:0] code_s1,
	input  logic [TIMEOUT_W-1:0]  timeout_ms,
	input  logic [SIGNS_W-1:0]    signs_count,
	output logic                  advance,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_flags_t            res_flags,
	output logic [CODE_WIDTH-1:0] res_code
);

	localparam int CMP_W = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT_HIGH,
		PH_WAIT_LOW2,
		PH_B1,
		PH_B2,
		PH_B3,
		PH_B4,
		PH_ERROR
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [COUNT_W-1:0]     count_q, count_d;
	logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
	logic                   res_valid_q;
	res_flags_t             res_flags_q, flags_d;
	logic [CODE_WIDTH-1:0]  res_code_q, code_d;
	logic                   fire;
	logic                   timed_out;
	logic                   strobe_hit;
	logic [COUNT_W-1:0]     count_inc;

	// result register is free when empty or being taken
	assign advance   = !res_valid_q || res_ready;
	assign fire      = valid_s1 && advance;
	assign res_valid = res_valid_q;
	assign res_flags = res_flags_q;
	assign res_code  = res_code_q;

	// one sample step
	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		elapsed_d  = elapsed_q;
		flags_d    = '0;
		code_d     = '0;
		timed_out  = 1'b0;
		strobe_hit = 1'b0;
		count_inc  = (count_q == {COUNT_W{1'b1}}) ? count_q : count_q + 1'b1;

		// strobe of the axis that is awaited
		case (phase_q)
			PH_B1:   strobe_hit = flags_s1.strobe[0];
			PH_B2:   strobe_hit = flags_s1.strobe[1];
			PH_B3:   strobe_hit = flags_s1.strobe[2];
			PH_B4:   strobe_hit = flags_s1.strobe[3];
			default: strobe_hit = 1'b0;
		endcase

		if (flags_s1.restart) begin
			phase_d   = PH_IDLE;
			elapsed_d = '0;
		end else if (phase_q == PH_IDLE) begin
			elapsed_d = '0;
			if (!flags_s1.frame_line) begin
				phase_d = PH_WAIT_HIGH;
			end
		end else begin
			// saturating millisecond timer, checked before any other move
			if (flags_s1.ms_tick && (elapsed_q != {TIMER_WIDTH{1'b1}})) begin
				elapsed_d = elapsed_q + 1'b1;
			end
			timed_out = (phase_q != PH_ERROR) &&
				(CMP_W'(elapsed_d) >= CMP_W'(timeout_ms));
			if (timed_out) begin
				phase_d = PH_ERROR;
			end else begin
				case (phase_q)
					PH_WAIT_HIGH: begin
						if (flags_s1.frame_line) begin
							if (flags_s1.buffer_free) begin
								count_d             = '0;
								flags_d.frame_start = 1'b1;
								phase_d             = PH_WAIT_LOW2;
							end else begin
								phase_d = PH_IDLE;
							end
						end
					end
					PH_WAIT_LOW2: begin
						if (!flags_s1.frame_line) begin
							phase_d = PH_B1;
						end
					end
					PH_B1, PH_B2, PH_B3, PH_B4: begin
						if (strobe_hit) begin
							flags_d.capture_valid = 1'b1;
							code_d                = code_s1;
							count_d               = count_inc;
							if (phase_q == PH_B4) begin
								if (count_inc >= signs_count) begin
									flags_d.frame_done = 1'b1;
									phase_d            = PH_IDLE;
								end else begin
									phase_d = PH_B1;
								end
							end else begin
								phase_d = phase_t'(phase_q + 3'd1);
							end
						end
					end
					default: phase_d = phase_q;
				endcase
			end
			flags_d.timeout_error = (phase_d == PH_ERROR);
		end
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			elapsed_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q   <= phase_d;
				count_q   <= count_d;
				elapsed_q <= elapsed_d;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_flags_q <= flags_d;
			res_code_q  <= code_d;
		end
	end

	// a completed frame always comes with its last capture
	a_done_has_capture: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_flags_q.frame_done |-> res_flags_q.capture_valid)
		else $error("frame_done without a capture");

	// no capture and no frame event are reported in the error phase
	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_flags_q.timeout_error |->
		!res_flags_q.capture_valid && !res_flags_q.frame_start &&
		!res_flags_q.frame_done)
		else $error("event reported together with timeout error");

	// the error phase is left only on restart
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == PH_ERROR) && !flags_s1.restart |=> phase_q == PH_ERROR)
		else $error("error phase left without restart");

	// timer is cleared by every idle or restart step
	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ((phase_q == PH_IDLE) || flags_s1.restart) |=> elapsed_q == '0)
		else $error("timer not cleared after an idle step");

endmodule

// ----- src/strobed_digit_frame_capture_core.sv -----
// top level of the strobed digit frame capture block
`timescale 1ns / 1ps

// Strobed digit frame capture.
// The slave stream carries one sample of the frame line, the four axis strobes,
// the code word, buffer_free, ms_tick and restart per request. For every
// accepted request exactly one result request leaves on the master stream:
// capture flag, captured code, frame start, timeout error, and tlast for the
// frame completing on that sample.
// A sample passes through the input register, then through the sequencer step into
// the result register.
// Throughput: one sample per cycle while the result stream is not stalled; the
// sequencer takes a new sample whenever its result is taken, so samples stream back to back.
// Configuration (timeout_ms, signs_count) is written through cfg_we/cfg_index/
// cfg_wdata while no sample is in flight.
// Reset clears the sequencer to idle, the counter and timer to zero, the
// registers to 100 ms and 32 signs, and empties both stages.
// When the receiver stalls, the result is held and the input stage takes one more
// sample only if it is empty; after that s_tready drops until the result is taken.

module strobed_digit_frame_capture_core
	import sdfc_pkg::*;
#(
	parameter int CODE_WIDTH  = 8,
	parameter int TIMER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// sample stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// frame_line, strobe_b1, strobe_b2, strobe_b3, strobe_b4, code_in,
	// buffer_free, ms_tick, restart, zero fill
	input  logic [((CODE_WIDTH+8+7)/8)*8-1:0] s_tdata,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// capture_valid, code_out, frame_start, timeout_error, zero fill
	output logic [((CODE_WIDTH+3+7)/8)*8-1:0] m_tdata,
	output logic                 m_tlast   // frame_done
);

	localparam int IN_W  = ((CODE_WIDTH + 8 + 7) / 8) * 8;
	localparam int OUT_W = ((CODE_WIDTH + 3 + 7) / 8) * 8;

	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [SIGNS_W-1:0]    signs_q;
	smp_flags_t            in_flags;
	smp_flags_t            flags_s1;
	logic [CODE_WIDTH-1:0] code_s1;
	logic                  valid_s1;
	logic                  advance;
	res_flags_t            res_flags;
	logic [CODE_WIDTH-1:0] res_code;
	logic [IN_W-1:0]       in_unused;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			signs_q   <= SIGNS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT_MS:  timeout_q <= cfg_wdata[TIMEOUT_W-1:0];
				REG_SIGNS_COUNT: signs_q   <= cfg_wdata[SIGNS_W-1:0];
				default:         timeout_q <= timeout_q;
			endcase
		end
	end

	// unpack the sample
	assign in_flags.frame_line  = s_tdata[0];
	assign in_flags.strobe      = s_tdata[4:1];
	assign in_flags.buffer_free = s_tdata[CODE_WIDTH+5];
	assign in_flags.ms_tick     = s_tdata[CODE_WIDTH+6];
	assign in_flags.restart     = s_tdata[CODE_WIDTH+7];
	assign in_unused            = s_tdata;

	sdfc_in_stage #(
		.CODE_WIDTH(CODE_WIDTH)
	) u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_flags(in_flags),
		.in_code (in_unused[CODE_WIDTH+4:5]),
		.advance (advance),
		.valid_s1(valid_s1),
		.flags_s1(flags_s1),
		.code_s1 (code_s1)
	);

	sdfc_step #(
		.CODE_WIDTH (CODE_WIDTH),
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.flags_s1   (flags_s1),
		.code_s1    (code_s1),
		.timeout_ms (timeout_q),
		.signs_count(signs_q),
		.advance    (advance),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_flags  (res_flags),
		.res_code   (res_code)
	);

	// pack the result
	assign m_tdata = OUT_W'({res_flags.timeout_error, res_flags.frame_start,
		res_code, res_flags.capture_valid});
	assign m_tlast = res_flags.frame_done;

endmodule

// ----- sim/strobed_digit_frame_capture_checker.sv -----
// result checker of the strobed digit frame capture block: predicts each result and compares
`timescale 1ns / 1ps

module strobed_digit_frame_capture_checker
	import sdfc_pkg::*;
#(
	parameter int SDATA_W = 16,
	parameter int MDATA_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// frame_line, strobe_b1..b4, code_in, buffer_free, ms_tick, restart
	input  logic [SDATA_W-1:0]   s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// capture_valid, code_out, frame_start, timeout_error, zero fill
	input  logic [MDATA_W-1:0]   m_tdata,
	input  logic                 m_tlast,
	output int                   fail_count,
	output int                   pending,
	output int                   captures,
	output int                   frames_closed,
	output int                   error_entries
);

	// sequencer phases of the capture
	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_WAIT_HIGH, SEQ_WAIT_LOW, SEQ_B1, SEQ_B2, SEQ_B3, SEQ_B4, SEQ_ERROR
	} seq_t;

	// one result: flag fields and the captured code
	typedef struct packed {
		res_flags_t flags;
		logic [7:0] code;
	} outcome_t;

	// predicted state and register copies
	seq_t                  seq           = SEQ_IDLE;
	logic [COUNT_W-1:0]    capture_cnt   = '0;
	logic [15:0]           ms_elapsed    = '0;
	logic [TIMEOUT_W-1:0]  timeout_limit = TIMEOUT_RESET;
	logic [SIGNS_W-1:0]    signs_needed  = SIGNS_RESET;

	outcome_t expected_q[$];
	outcome_t oldest;
	outcome_t observed;
	int       results_seen;

	// advance the predicted sequencer by one sample and return its result
	function automatic outcome_t step_sequencer(smp_flags_t f, logic [7:0] code);
		outcome_t r;
		int       lane;
		logic     was_error;
		r = '0;
		was_error = (seq == SEQ_ERROR);
		if (f.restart) begin
			seq = SEQ_IDLE;
			ms_elapsed = '0;
			return r;
		end
		if (seq == SEQ_IDLE) begin
			ms_elapsed = '0;
			if (!f.frame_line)
				seq = SEQ_WAIT_HIGH;
		end else begin
			// saturating millisecond timer, checked before any other move
			if (f.ms_tick && ms_elapsed != '1)
				ms_elapsed++;
			if (seq != SEQ_ERROR && ms_elapsed >= timeout_limit) begin
				seq = SEQ_ERROR;
			end else begin
				case (seq)
					SEQ_WAIT_HIGH: begin
						if (f.frame_line) begin
							if (f.buffer_free) begin
								capture_cnt = '0;
								r.flags.frame_start = 1'b1;
								seq = SEQ_WAIT_LOW;
							end else begin
								seq = SEQ_IDLE;
							end
						end
					end
					SEQ_WAIT_LOW: begin
						if (!f.frame_line)
							seq = SEQ_B1;
					end
					SEQ_B1, SEQ_B2, SEQ_B3, SEQ_B4: begin
						lane = int'(seq) - int'(SEQ_B1);
						if (f.strobe[lane]) begin
							r.flags.capture_valid = 1'b1;
							r.code = code;
							if (capture_cnt != '1)
								capture_cnt++;
							if (seq == SEQ_B4) begin
								if (capture_cnt >= signs_needed) begin
									r.flags.frame_done = 1'b1;
									seq = SEQ_IDLE;
								end else begin
									seq = SEQ_B1;
								end
							end else begin
								seq = seq.next();
							end
						end
					end
					default: ;
				endcase
			end
		end
		r.flags.timeout_error = (seq == SEQ_ERROR);
		// run statistics
		if (r.flags.capture_valid)
			captures++;
		if (r.flags.frame_done)
			frames_closed++;
		if (r.flags.timeout_error && !was_error)
			error_entries++;
		return r;
	endfunction

	// compare one field, report the first ten differences
	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
					name, results_seen, want, got);
		end
	endtask

	// watch both streams and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq = SEQ_IDLE;
			capture_cnt = '0;
			ms_elapsed = '0;
			timeout_limit = TIMEOUT_RESET;
			signs_needed = SIGNS_RESET;
			expected_q.delete();
			pending <= 0;
		end else begin
			// result request leaving the block
			if (m_tvalid && m_tready) begin
				results_seen++;
				observed.flags = '{timeout_error: m_tdata[10], frame_done: m_tlast,
					frame_start: m_tdata[9], capture_valid: m_tdata[0]};
				observed.code = m_tdata[8:1];
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result %0d arrived with nothing outstanding", results_seen);
				end else begin
					oldest = expected_q.pop_front();
					check_field("capture_valid", oldest.flags.capture_valid,
						observed.flags.capture_valid);
					check_field("code_out", oldest.code, observed.code);
					check_field("frame_start", oldest.flags.frame_start,
						observed.flags.frame_start);
					check_field("frame_done", oldest.flags.frame_done,
						observed.flags.frame_done);
					check_field("timeout_error", oldest.flags.timeout_error,
						observed.flags.timeout_error);
				end
			end
			// sample request entering the block
			if (s_tvalid && s_tready)
				expected_q.push_back(step_sequencer(
					smp_flags_t'({s_tdata[15:13], s_tdata[4:0]}), s_tdata[12:5]));
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT_MS:  timeout_limit = cfg_wdata[TIMEOUT_W-1:0];
					REG_SIGNS_COUNT: signs_needed = cfg_wdata[SIGNS_W-1:0];
					default: ;
				endcase
			end
			pending <= expected_q.size();
		end
	end

endmodule

// ----- sim/strobed_digit_frame_capture_core_test.sv -----
// testbench top of the strobed digit frame capture block: stimulus, stalls and verdict
`timescale 1ns / 1ps

module strobed_digit_frame_capture_core_test;
	import sdfc_pkg::*;

	localparam int SDATA_W     = ((8 + 8 + 7) / 8) * 8;
	localparam int MDATA_W     = ((8 + 3 + 7) / 8) * 8;
	localparam int PHASES      = 6;
	localparam int HOLD_CYCLES = 150;
	localparam int QUIET_LIMIT = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	// frame_line, strobe_b1..b4, code_in, buffer_free, ms_tick, restart
	logic [SDATA_W-1:0]   s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	// capture_valid, code_out, frame_start, timeout_error, zero fill
	logic [MDATA_W-1:0]   m_tdata;
	logic                 m_tlast;

	int fail_count;
	int pending;
	int captures;
	int frames_closed;
	int error_entries;

	// per-phase register settings, ms tick density and sample budget
	int unsigned timeout_plan[PHASES] = '{100, 1, 65535, 3, 20, 65535};
	int unsigned signs_plan[PHASES]   = '{32, 1, 255, 4, 8, 1};
	int          tick_plan[PHASES]    = '{3, 8, 40, 15, 10, 50};
	int          budget_plan[PHASES]  = '{140, 110, 200, 110, 110, 100};

	int send_idle_pct;
	int stall_pct;
	int tick_pct;
	int signs_now;
	int samples_sent;
	int restarts;
	bit hold_go;

	strobed_digit_frame_capture_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	strobed_digit_frame_capture_checker #(
		.SDATA_W (SDATA_W),
		.MDATA_W (MDATA_W)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending       (pending),
		.captures      (captures),
		.frames_closed (frames_closed),
		.error_entries (error_entries)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles with no traffic at all
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("no traffic for %0d cycles", QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic logic tick_now();
		return $urandom_range(99) < tick_pct;
	endfunction

	// offer one sample request, with random idle cycles in front
	task automatic send(input logic fl, input logic [3:0] st, input logic [7:0] cd,
			input logic bf, input logic tk, input logic rs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= SDATA_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rs, tk, bf, cd, st, fl};
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		if (rs)
			restarts++;
	endtask

	// fully random samples, restart now and then
	task automatic noise_burst(input int n);
		repeat (n)
			send(1'($urandom), 4'($urandom), 8'($urandom), 1'($urandom), tick_now(),
				$urandom_range(29) == 0);
	endtask

	// well-formed frame with random content; rarely broken by a restart
	task automatic frame_run();
		int quads;
		int k;
		int lane;
		quads = (signs_now + 3) / 4;
		if ($urandom_range(2) == 0)
			send(1'($urandom), 4'($urandom), 8'($urandom), 1'($urandom), tick_now(), 1'b1);
		// frame low, high (buffer usually free), low
		send(1'b0, 4'($urandom), 8'($urandom), 1'($urandom), tick_now(), 1'b0);
		send(1'b1, 4'($urandom), 8'($urandom), $urandom_range(9) != 0, tick_now(), 1'b0);
		repeat ($urandom_range(2))
			send(1'b1, 4'($urandom), 8'($urandom), 1'($urandom), tick_now(), 1'b0);
		send(1'b0, 4'($urandom), 8'($urandom), 1'($urandom), tick_now(), 1'b0);
		// strobes in turn, with samples lacking the awaited strobe in between
		for (k = 0; k < quads * 4; k++) begin
			lane = k % 4;
			while ($urandom_range(3) == 0)
				send(1'($urandom), 4'($urandom) & ~(4'b0001 << lane), 8'($urandom),
					1'($urandom), tick_now(), 1'b0);
			if ($urandom_range(199) == 0)
				send(1'($urandom), 4'($urandom), 8'($urandom), 1'($urandom), tick_now(), 1'b1);
			send(1'($urandom), 4'($urandom) | (4'b0001 << lane), 8'($urandom),
				1'($urandom), tick_now(), 1'b0);
		end
	endtask

	// write both registers while nothing is in flight
	task automatic apply_settings(input int unsigned timeout_val, input int unsigned signs_val);
		cfg_we <= 1'b1;
		cfg_index <= REG_TIMEOUT_MS;
		cfg_wdata <= CFG_W'(timeout_val);
		@(posedge clk);
		cfg_index <= REG_SIGNS_COUNT;
		cfg_wdata <= CFG_W'(signs_val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int p;
		int base;
		bit hold_done;
		hold_done = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 59; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 59; end
				default: begin send_idle_pct = 37; stall_pct = 37; end
			endcase
			tick_pct = tick_plan[p];
			signs_now = signs_plan[p];
			// reset values stand in the first phase
			if (p > 0)
				apply_settings(timeout_plan[p], signs_plan[p]);

			if (p == 0) begin
				// restart at idle, frame high at idle, no free buffer, then a frame
				send(1'b1, 4'hF, 8'hFF, 1'b1, 1'b1, 1'b1);
				send(1'b1, 4'h0, 8'h00, 1'b0, 1'b0, 1'b0);
				send(1'b0, 4'h0, 8'h00, 1'b1, 1'b0, 1'b0);
				send(1'b1, 4'h0, 8'h00, 1'b0, 1'b0, 1'b0);
				send(1'b0, 4'h0, 8'h00, 1'b0, 1'b0, 1'b0);
				send(1'b1, 4'h0, 8'h00, 1'b1, 1'b0, 1'b0);
				send(1'b1, 4'h0, 8'h00, 1'b1, 1'b0, 1'b0);
				send(1'b0, 4'h0, 8'h00, 1'b1, 1'b0, 1'b0);
				// wrong strobes are ignored, then all four lanes with edge codes
				send(1'b0, 4'b1110, 8'h33, 1'b1, 1'b1, 1'b0);
				send(1'b0, 4'b0001, 8'hFF, 1'b0, 1'b0, 1'b0);
				send(1'b1, 4'b0010, 8'h00, 1'b0, 1'b0, 1'b0);
				send(1'b0, 4'b0100, 8'hA5, 1'b0, 1'b0, 1'b0);
				send(1'b1, 4'b1000, 8'h5A, 1'b0, 1'b0, 1'b0);
				// restart in the middle of a frame
				send(1'b0, 4'hF, 8'h77, 1'b1, 1'b0, 1'b1);
			end else if (p == 1) begin
				// a tick after frame start times out; error holds until restart
				send(1'b0, 4'h0, 8'h00, 1'b0, 1'b0, 1'b1);
				send(1'b0, 4'h0, 8'h00, 1'b0, 1'b0, 1'b0);
				send(1'b1, 4'h0, 8'h00, 1'b1, 1'b0, 1'b0);
				send(1'b0, 4'h0, 8'h00, 1'b1, 1'b0, 1'b0);
				send(1'b0, 4'b0001, 8'hC3, 1'b1, 1'b1, 1'b0);
				send(1'b0, 4'hF, 8'h3C, 1'b1, 1'b1, 1'b0);
				send(1'b0, 4'h0, 8'h00, 1'b0, 1'b0, 1'b1);
				// a single sign closes the frame after the first lane four capture
				send(1'b0, 4'h0, 8'h00, 1'b0, 1'b0, 1'b0);
				send(1'b1, 4'h0, 8'h00, 1'b1, 1'b0, 1'b0);
				send(1'b0, 4'h0, 8'h00, 1'b0, 1'b0, 1'b0);
				send(1'b0, 4'b0001, 8'h01, 1'b0, 1'b0, 1'b0);
				send(1'b0, 4'b0010, 8'h80, 1'b0, 1'b0, 1'b0);
				send(1'b0, 4'b0100, 8'h7F, 1'b0, 1'b0, 1'b0);
				send(1'b0, 4'b1000, 8'hFE, 1'b0, 1'b0, 1'b0);
			end

			base = samples_sent;
			while (samples_sent - base < budget_plan[p]) begin
				// long receiver hold-off while samples keep coming
				if (p == 0 && !hold_done && samples_sent - base > 60) begin
					hold_go = 1'b1;
					hold_done = 1'b1;
				end
				if ($urandom_range(3) == 0)
					noise_burst($urandom_range(1, 6));
				else
					frame_run();
			end

			// drain before the next register change
			s_tvalid <= 1'b0;
			do @(posedge clk); while (pending != 0);
			repeat (4) @(posedge clk);
		end

		$display("run covered %0d samples over %0d register settings with %0d restarts",
			samples_sent, PHASES, restarts);
		$display("%0d codes captured, %0d frames closed, %0d timeout errors raised",
			captures, frames_closed, error_entries);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sdfc_pkg.sv
src/sdfc_in_stage.sv
src/sdfc_step.sv
src/strobed_digit_frame_capture_core.sv
sim/strobed_digit_frame_capture_checker.sv
sim/strobed_digit_frame_capture_core_test.sv
